>>> rtl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg: shared types, constants and microprogram for the orbit camera unit
// word and vector types, saturation, arctangent table, microcode per command
// ----------------------------------------------------------------------------
package ocp_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ANG_FRAC     = 16;
	localparam int CW           = 30;
	localparam int ANG_W        = 19;
	localparam int STEP_W       = 5;
	localparam int PC_W         = 6;
	localparam int S_DATA_W     = 152;
	localparam int M_DATA_W     = 384;

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0] vec3_t;

	localparam word_t ONE_Q = 32'sd1 <<< FRAC_BITS;
	localparam word_t NEG_ONE_Q = -ONE_Q;

	localparam logic [2:0] MODE_INIT  = 3'd0;
	localparam logic [2:0] MODE_FWD   = 3'd1;
	localparam logic [2:0] MODE_RIGHT = 3'd2;
	localparam logic [2:0] MODE_YAW   = 3'd3;
	localparam logic [2:0] MODE_PITCH = 3'd4;
	localparam logic [2:0] MODE_ROLL  = 3'd5;

	localparam vec3_t POS_RST = {32'sd0, 32'sd0, 32'sd0};
	localparam vec3_t FWD_RST = {NEG_ONE_Q, 32'sd0, 32'sd0};
	localparam vec3_t UP_RST  = {32'sd0, ONE_Q, 32'sd0};
	localparam vec3_t RGT_RST = {32'sd0, 32'sd0, ONE_Q};

	typedef enum logic [3:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_MULA, OP_MULS, OP_CORD, OP_NORM, OP_END
	} op_t;

	typedef enum logic [4:0] {
		R_P0, R_P1, R_P2, R_F0, R_F1, R_F2, R_U0, R_U1, R_U2, R_R0, R_R1, R_R2,
		R_O0, R_O1, R_O2, R_CS, R_SN, R_DS, R_T0, R_T1, R_VX, R_VY, R_VZ,
		R_K0, R_K1, R_KM
	} rsel_t;

	localparam int NUM_SRC = 32;

	typedef struct packed {
		op_t   op;
		rsel_t dst;
		rsel_t a;
		rsel_t b;
	} uop_t;

	function automatic word_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic [29:0] atan_cw(input logic [STEP_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic uop_t mk(input op_t o, input rsel_t d, input rsel_t a, input rsel_t b);
		uop_t u;
		u.op = o;
		u.dst = d;
		u.a = a;
		u.b = b;
		return u;
	endfunction

	// position shift that keeps the point of interest fixed
	function automatic uop_t pos_uop(input logic [3:0] k);
		uop_t u;
		case (k)
			4'd0:  u = mk(OP_MUL, R_T0, R_O0, R_DS);
			4'd1:  u = mk(OP_ADD, R_P0, R_P0, R_T0);
			4'd2:  u = mk(OP_MUL, R_T1, R_F0, R_DS);
			4'd3:  u = mk(OP_SUB, R_P0, R_P0, R_T1);
			4'd4:  u = mk(OP_MUL, R_T0, R_O1, R_DS);
			4'd5:  u = mk(OP_ADD, R_P1, R_P1, R_T0);
			4'd6:  u = mk(OP_MUL, R_T1, R_F1, R_DS);
			4'd7:  u = mk(OP_SUB, R_P1, R_P1, R_T1);
			4'd8:  u = mk(OP_MUL, R_T0, R_O2, R_DS);
			4'd9:  u = mk(OP_ADD, R_P2, R_P2, R_T0);
			4'd10: u = mk(OP_MUL, R_T1, R_F2, R_DS);
			4'd11: u = mk(OP_SUB, R_P2, R_P2, R_T1);
			default: u = mk(OP_END, R_K0, R_K0, R_K0);
		endcase
		return u;
	endfunction

	function automatic uop_t save_uop(input logic [1:0] k);
		uop_t u;
		case (k)
			2'd0:    u = mk(OP_MOV, R_O0, R_F0, R_K0);
			2'd1:    u = mk(OP_MOV, R_O1, R_F1, R_K0);
			default: u = mk(OP_MOV, R_O2, R_F2, R_K0);
		endcase
		return u;
	endfunction

	function automatic uop_t uop_at(input logic [2:0] mode, input logic [PC_W-1:0] pc);
		logic [PC_W-1:0] k;
		uop_t u;
		k = pc - PC_W'(1);
		u = mk(OP_END, R_K0, R_K0, R_K0);
		case (mode)
			MODE_INIT: begin
				case (pc)
					6'd0:  u = mk(OP_MOV, R_P0, R_VX, R_K0);
					6'd1:  u = mk(OP_MOV, R_P1, R_VY, R_K0);
					6'd2:  u = mk(OP_MOV, R_P2, R_VZ, R_K0);
					6'd3:  u = mk(OP_MOV, R_F0, R_K0, R_K0);
					6'd4:  u = mk(OP_MOV, R_F1, R_K0, R_K0);
					6'd5:  u = mk(OP_MOV, R_F2, R_KM, R_K0);
					6'd6:  u = mk(OP_MOV, R_U0, R_K0, R_K0);
					6'd7:  u = mk(OP_MOV, R_U1, R_K1, R_K0);
					6'd8:  u = mk(OP_MOV, R_U2, R_K0, R_K0);
					6'd9:  u = mk(OP_MOV, R_R0, R_K1, R_K0);
					6'd10: u = mk(OP_MOV, R_R1, R_K0, R_K0);
					6'd11: u = mk(OP_MOV, R_R2, R_K0, R_K0);
					default: u = mk(OP_END, R_K0, R_K0, R_K0);
				endcase
			end
			MODE_FWD, MODE_RIGHT: begin
				case (pc)
					6'd0: u = mk(OP_MUL, R_T0, R_VX, R_DS);
					6'd1: u = mk(OP_ADD, R_P0, R_P0, R_T0);
					6'd2: u = mk(OP_MUL, R_T0, R_VY, R_DS);
					6'd3: u = mk(OP_ADD, R_P1, R_P1, R_T0);
					6'd4: u = mk(OP_MUL, R_T0, R_VZ, R_DS);
					6'd5: u = mk(OP_ADD, R_P2, R_P2, R_T0);
					default: u = mk(OP_END, R_K0, R_K0, R_K0);
				endcase
			end
			MODE_YAW: begin
				if (pc >= PC_W'(22) && pc <= PC_W'(33)) begin
					k = pc - PC_W'(22);
					u = pos_uop(k[3:0]);
				end else if (pc >= PC_W'(1) && pc <= PC_W'(3)) begin
					u = save_uop(k[1:0]);
				end else begin
					case (pc)
						6'd0:  u = mk(OP_CORD, R_K0, R_K0, R_K0);
						6'd4:  u = mk(OP_MUL, R_T0, R_F0, R_CS);
						6'd5:  u = mk(OP_MUL, R_T1, R_R0, R_SN);
						6'd6:  u = mk(OP_ADD, R_F0, R_T0, R_T1);
						6'd7:  u = mk(OP_MUL, R_T0, R_F1, R_CS);
						6'd8:  u = mk(OP_MUL, R_T1, R_R1, R_SN);
						6'd9:  u = mk(OP_ADD, R_F1, R_T0, R_T1);
						6'd10: u = mk(OP_MUL, R_T0, R_F2, R_CS);
						6'd11: u = mk(OP_MUL, R_T1, R_R2, R_SN);
						6'd12: u = mk(OP_ADD, R_F2, R_T0, R_T1);
						6'd13: u = mk(OP_MULA, R_K0, R_F1, R_U2);
						6'd14: u = mk(OP_MULS, R_R0, R_F2, R_U1);
						6'd15: u = mk(OP_MULA, R_K0, R_F2, R_U0);
						6'd16: u = mk(OP_MULS, R_R1, R_F0, R_U2);
						6'd17: u = mk(OP_MULA, R_K0, R_F0, R_U1);
						6'd18: u = mk(OP_MULS, R_R2, R_F1, R_U0);
						6'd19: u = mk(OP_NORM, R_K0, R_F0, R_K0);
						6'd20: u = mk(OP_NORM, R_K0, R_R0, R_K0);
						6'd21: u = mk(OP_NORM, R_K0, R_U0, R_K0);
						default: u = mk(OP_END, R_K0, R_K0, R_K0);
					endcase
				end
			end
			MODE_PITCH: begin
				if (pc >= PC_W'(21) && pc <= PC_W'(32)) begin
					k = pc - PC_W'(21);
					u = pos_uop(k[3:0]);
				end else if (pc >= PC_W'(1) && pc <= PC_W'(3)) begin
					u = save_uop(k[1:0]);
				end else begin
					case (pc)
						6'd0:  u = mk(OP_CORD, R_K0, R_K0, R_K0);
						6'd4:  u = mk(OP_MUL, R_T0, R_U0, R_CS);
						6'd5:  u = mk(OP_MUL, R_T1, R_F0, R_SN);
						6'd6:  u = mk(OP_ADD, R_U0, R_T0, R_T1);
						6'd7:  u = mk(OP_MUL, R_T0, R_U1, R_CS);
						6'd8:  u = mk(OP_MUL, R_T1, R_F1, R_SN);
						6'd9:  u = mk(OP_ADD, R_U1, R_T0, R_T1);
						6'd10: u = mk(OP_MUL, R_T0, R_U2, R_CS);
						6'd11: u = mk(OP_MUL, R_T1, R_F2, R_SN);
						6'd12: u = mk(OP_ADD, R_U2, R_T0, R_T1);
						6'd13: u = mk(OP_MULA, R_K0, R_U1, R_R2);
						6'd14: u = mk(OP_MULS, R_F0, R_U2, R_R1);
						6'd15: u = mk(OP_MULA, R_K0, R_U2, R_R0);
						6'd16: u = mk(OP_MULS, R_F1, R_U0, R_R2);
						6'd17: u = mk(OP_MULA, R_K0, R_U0, R_R1);
						6'd18: u = mk(OP_MULS, R_F2, R_U1, R_R0);
						6'd19: u = mk(OP_NORM, R_K0, R_F0, R_K0);
						6'd20: u = mk(OP_NORM, R_K0, R_U0, R_K0);
						default: u = mk(OP_END, R_K0, R_K0, R_K0);
					endcase
				end
			end
			MODE_ROLL: begin
				case (pc)
					6'd0:  u = mk(OP_CORD, R_K0, R_K0, R_K0);
					6'd1:  u = mk(OP_MUL, R_T0, R_U0, R_SN);
					6'd2:  u = mk(OP_MUL, R_T1, R_R0, R_CS);
					6'd3:  u = mk(OP_ADD, R_R0, R_T0, R_T1);
					6'd4:  u = mk(OP_MUL, R_T0, R_U1, R_SN);
					6'd5:  u = mk(OP_MUL, R_T1, R_R1, R_CS);
					6'd6:  u = mk(OP_ADD, R_R1, R_T0, R_T1);
					6'd7:  u = mk(OP_MUL, R_T0, R_U2, R_SN);
					6'd8:  u = mk(OP_MUL, R_T1, R_R2, R_CS);
					6'd9:  u = mk(OP_ADD, R_R2, R_T0, R_T1);
					6'd10: u = mk(OP_MULA, R_K0, R_R1, R_F2);
					6'd11: u = mk(OP_MULS, R_U0, R_R2, R_F1);
					6'd12: u = mk(OP_MULA, R_K0, R_R2, R_F0);
					6'd13: u = mk(OP_MULS, R_U1, R_R0, R_F2);
					6'd14: u = mk(OP_MULA, R_K0, R_R0, R_F1);
					6'd15: u = mk(OP_MULS, R_U2, R_R1, R_F0);
					6'd16: u = mk(OP_NORM, R_K0, R_U0, R_K0);
					6'd17: u = mk(OP_NORM, R_K0, R_R0, R_K0);
					default: u = mk(OP_END, R_K0, R_K0, R_K0);
				endcase
			end
			default: u = mk(OP_END, R_K0, R_K0, R_K0);
		endcase
		return u;
	endfunction

endpackage

>>> rtl/ocp_alu.sv
// ----------------------------------------------------------------------------
// ocp_alu: shared multiply / add unit
// rounded fixed point product, saturating add, subtract and product difference
// ----------------------------------------------------------------------------
module ocp_alu (
	input  ocp_pkg::op_t        op,
	input  ocp_pkg::word_t      a,
	input  ocp_pkg::word_t      b,
	input  logic signed [63:0]  acc,
	output ocp_pkg::word_t      res,
	output logic signed [63:0]  prod_rnd
);
	import ocp_pkg::*;

	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic signed [63:0] dif;

	always_comb begin
		prod = a * b;
		prod_rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		sum = a + b;
		dif = a - b;
		unique case (op)
			OP_ADD:  res = sat32(sum);
			OP_SUB:  res = sat32(dif);
			OP_MUL:  res = sat32(prod_rnd);
			OP_MULS: res = sat32(acc - prod_rnd);
			default: res = a;
		endcase
	end

endmodule

>>> rtl/ocp_cordic.sv
// ----------------------------------------------------------------------------
// ocp_cordic: iterative sine / cosine
// rotation mode, one step per cycle, fold by pi beyond a quarter turn
// ----------------------------------------------------------------------------
module ocp_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ocp_pkg::ANG_W-1:0]   angle,
	output logic                               done,
	output ocp_pkg::word_t                     cs,
	output ocp_pkg::word_t                     sn
);
	import ocp_pkg::*;

	localparam int ZW = 36;
	localparam logic signed [ZW-1:0] PI_CW      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_CW = 36'sd1686629713;
	localparam logic signed [ZW-1:0] GAIN_CW    = 36'sd652032874;
	localparam logic signed [ZW-1:0] HALF_LSB   = 36'sd1 <<< (CW - FRAC_BITS - 1);
	localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_OUT} cst_t;

	cst_t              st_q;
	logic [STEP_W-1:0] i_q;
	logic signed [ZW-1:0] x_q, y_q, z_q;
	logic              flip_q;
	logic signed [ZW-1:0] z0, zf, dx, dy, at, xo, yo;
	logic              fold;

	always_comb begin
		z0 = ZW'(angle) <<< (CW - ANG_FRAC);
		fold = 1'b1;
		if (z0 > HALF_PI_CW) zf = z0 - PI_CW;
		else if (z0 < -HALF_PI_CW) zf = z0 + PI_CW;
		else begin
			zf = z0;
			fold = 1'b0;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = ZW'(atan_cw(i_q));
		xo = ((flip_q ? -x_q : x_q) + HALF_LSB) >>> (CW - FRAC_BITS);
		yo = ((flip_q ? -y_q : y_q) + HALF_LSB) >>> (CW - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			done <= 1'b0;
			i_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			flip_q <= 1'b0;
			cs <= '0;
			sn <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				C_IDLE: begin
					if (start) begin
						x_q <= GAIN_CW;
						y_q <= '0;
						z_q <= zf;
						flip_q <= fold;
						i_q <= '0;
						st_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					i_q <= i_q + STEP_W'(1);
					if (i_q == STEP_LAST) st_q <= C_OUT;
				end
				C_OUT: begin
					cs <= sat32(64'(xo));
					sn <= sat32(64'(yo));
					done <= 1'b1;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/ocp_norm.sv
// ----------------------------------------------------------------------------
// ocp_norm: vector normalizer
// sum of squares, bit-pair square root, restoring division per component
// ----------------------------------------------------------------------------
module ocp_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ocp_pkg::vec3_t  vin,
	output logic            done,
	output ocp_pkg::vec3_t  vout
);
	import ocp_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int BW = $clog2(NW);
	localparam logic [BW-1:0] DIV_LAST = BW'(NW - 1);

	typedef enum logic [2:0] {N_IDLE, N_SQ, N_ROOT, N_LOAD, N_DIV, N_OUT} nst_t;

	nst_t          st_q;
	vec3_t         v_q;
	logic [1:0]    idx_q;
	logic [63:0]   sum_q, s_q, res_q, bit_q;
	logic [4:0]    cnt_q;
	logic [32:0]   len_q;
	logic [NW-1:0] num_q, quo_q;
	logic [33:0]   rem_q;
	logic [BW-1:0] dcnt_q;
	logic          neg_q;

	logic [31:0]   mag;
	logic [63:0]   sum_n, t, res_n;
	logic          ge_root, ge_div;
	logic [33:0]   rem_n;
	logic [NW-1:0] quo_n;
	logic [31:0]   q32;

	assign vout = v_q;

	always_comb begin
		mag = v_q[idx_q][31] ? 32'(-v_q[idx_q]) : 32'(v_q[idx_q]);
		sum_n = sum_q + 64'(mag) * 64'(mag);
		t = res_q + bit_q;
		ge_root = (s_q >= t);
		res_n = ge_root ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		rem_n = {rem_q[32:0], num_q[NW-1]};
		ge_div = (rem_n >= {1'b0, len_q});
		quo_n = {quo_q[NW-2:0], ge_div};
		q32 = neg_q ? 32'(-quo_n) : quo_n[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
			done <= 1'b0;
			v_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			s_q <= '0;
			res_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						v_q <= vin;
						sum_q <= '0;
						idx_q <= '0;
						st_q <= N_SQ;
					end
				end
				N_SQ: begin
					sum_q <= sum_n;
					if (idx_q == 2'd2) begin
						// zero vector stays as it is
						if (sum_n == '0) st_q <= N_OUT;
						else begin
							s_q <= sum_n;
							res_q <= '0;
							bit_q <= 64'd1 << 62;
							cnt_q <= '0;
							st_q <= N_ROOT;
						end
					end else idx_q <= idx_q + 2'd1;
				end
				N_ROOT: begin
					if (ge_root) s_q <= s_q - t;
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						len_q <= res_n[32:0];
						idx_q <= '0;
						st_q <= N_LOAD;
					end
				end
				N_LOAD: begin
					num_q <= {mag, {FRAC_BITS{1'b0}}};
					neg_q <= v_q[idx_q][31];
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= '0;
					st_q <= N_DIV;
				end
				N_DIV: begin
					rem_q <= ge_div ? (rem_n - {1'b0, len_q}) : rem_n;
					quo_q <= quo_n;
					num_q <= num_q << 1;
					dcnt_q <= dcnt_q + BW'(1);
					if (dcnt_q == DIV_LAST) begin
						v_q[idx_q] <= q32;
						if (idx_q == 2'd2) st_q <= N_OUT;
						else begin
							idx_q <= idx_q + 2'd1;
							st_q <= N_LOAD;
						end
					end
				end
				N_OUT: begin
					done <= 1'b1;
					st_q <= N_IDLE;
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/orbit_camera_pose_update_unit.sv
// ----------------------------------------------------------------------------
// orbit_camera_pose_update_unit: third person camera pose keeper
// runs one command per request under a microcoded sequencer over a shared alu
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | angle, distance, vec_x, vec_y, vec_z, pad   | mode
//  m_      | out | pos_xyz, fwd_xyz, up_xyz, right_xyz         | -
//
// the sequencer issues one alu micro-op per cycle and waits on the cordic
// and normalize units; s_tready is high only while idle
// the result sits in an output register; the next request is taken while
// it waits, but a finished request holds until the register is free
// arst_n loads the reset pose: origin, forward -z, up +y, right +x
module orbit_camera_pose_update_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// angle, distance, vec_x, vec_y, vec_z, zero pad
	input  logic [ocp_pkg::S_DATA_W-1:0]    s_tdata,
	// mode
	input  logic [2:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z,
	// right_x, right_y, right_z
	output logic [ocp_pkg::M_DATA_W-1:0]    m_tdata
);
	import ocp_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_CORD, ST_NORM, ST_DONE} st_t;

	st_t              state_q;
	logic [PC_W-1:0]  pc_q;
	logic [2:0]       mode_q;
	logic signed [ANG_W-1:0] ang_q;
	word_t            ds_q, vx_q, vy_q, vz_q;
	vec3_t            pos_q, fwd_q, up_q, rgt_q, old_q;
	word_t            cs_q, sn_q, t0_q, t1_q;
	logic signed [63:0] acc_q;

	uop_t             u;
	word_t            src [NUM_SRC];
	word_t            opa, opb, alu_res;
	logic signed [63:0] alu_wide;
	logic             cord_start, cord_done, norm_start, norm_done;
	word_t            cord_cs, cord_sn;
	vec3_t            norm_in, norm_out;

	assign s_tready = (state_q == ST_IDLE);
	assign u = uop_at(mode_q, pc_q);
	assign cord_start = (state_q == ST_EXEC) && (u.op == OP_CORD);
	assign norm_start = (state_q == ST_EXEC) && (u.op == OP_NORM);

	// operand sources by register code
	always_comb begin
		for (int i = 0; i < NUM_SRC; i++) src[i] = '0;
		src[R_P0] = pos_q[0]; src[R_P1] = pos_q[1]; src[R_P2] = pos_q[2];
		src[R_F0] = fwd_q[0]; src[R_F1] = fwd_q[1]; src[R_F2] = fwd_q[2];
		src[R_U0] = up_q[0];  src[R_U1] = up_q[1];  src[R_U2] = up_q[2];
		src[R_R0] = rgt_q[0]; src[R_R1] = rgt_q[1]; src[R_R2] = rgt_q[2];
		src[R_O0] = old_q[0]; src[R_O1] = old_q[1]; src[R_O2] = old_q[2];
		src[R_CS] = cs_q; src[R_SN] = sn_q; src[R_DS] = ds_q;
		src[R_T0] = t0_q; src[R_T1] = t1_q;
		src[R_VX] = vx_q; src[R_VY] = vy_q; src[R_VZ] = vz_q;
		src[R_K1] = ONE_Q; src[R_KM] = NEG_ONE_Q;
		opa = src[u.a];
		opb = src[u.b];
		unique case (u.a)
			R_F0:    norm_in = fwd_q;
			R_U0:    norm_in = up_q;
			default: norm_in = rgt_q;
		endcase
	end

	ocp_alu u_alu (
		.op       (u.op),
		.a        (opa),
		.b        (opb),
		.acc      (acc_q),
		.res      (alu_res),
		.prod_rnd (alu_wide)
	);

	ocp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (ang_q),
		.done   (cord_done),
		.cs     (cord_cs),
		.sn     (cord_sn)
	);

	ocp_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vin    (norm_in),
		.done   (norm_done),
		.vout   (norm_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			mode_q <= '0;
			ang_q <= '0;
			ds_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			vz_q <= '0;
			pos_q <= POS_RST;
			fwd_q <= FWD_RST;
			up_q <= UP_RST;
			rgt_q <= RGT_RST;
			old_q <= '0;
			cs_q <= '0;
			sn_q <= '0;
			t0_q <= '0;
			t1_q <= '0;
			acc_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			// a new result reloads the register in the done state below
			if (m_tvalid && m_tready && state_q != ST_DONE) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						// latch the request
						mode_q <= s_tuser;
						ang_q <= s_tdata[18:0];
						ds_q <= s_tdata[50:19];
						vx_q <= s_tdata[82:51];
						vy_q <= s_tdata[114:83];
						vz_q <= s_tdata[146:115];
						pc_q <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (u.op)
						OP_END:  state_q <= ST_DONE;
						OP_CORD: state_q <= ST_CORD;
						OP_NORM: state_q <= ST_NORM;
						OP_MULA: begin
							acc_q <= alu_wide;
							pc_q <= pc_q + PC_W'(1);
						end
						default: begin
							// write back one alu result
							case (u.dst)
								R_P0: pos_q[0] <= alu_res;
								R_P1: pos_q[1] <= alu_res;
								R_P2: pos_q[2] <= alu_res;
								R_F0: fwd_q[0] <= alu_res;
								R_F1: fwd_q[1] <= alu_res;
								R_F2: fwd_q[2] <= alu_res;
								R_U0: up_q[0] <= alu_res;
								R_U1: up_q[1] <= alu_res;
								R_U2: up_q[2] <= alu_res;
								R_R0: rgt_q[0] <= alu_res;
								R_R1: rgt_q[1] <= alu_res;
								R_R2: rgt_q[2] <= alu_res;
								R_O0: old_q[0] <= alu_res;
								R_O1: old_q[1] <= alu_res;
								R_O2: old_q[2] <= alu_res;
								R_T0: t0_q <= alu_res;
								R_T1: t1_q <= alu_res;
								default: ;
							endcase
							pc_q <= pc_q + PC_W'(1);
						end
					endcase
				end
				ST_CORD: begin
					if (cord_done) begin
						cs_q <= cord_cs;
						sn_q <= cord_sn;
						pc_q <= pc_q + PC_W'(1);
						state_q <= ST_EXEC;
					end
				end
				ST_NORM: begin
					if (norm_done) begin
						unique case (u.a)
							R_F0:    fwd_q <= norm_out;
							R_U0:    up_q <= norm_out;
							default: rgt_q <= norm_out;
						endcase
						pc_q <= pc_q + PC_W'(1);
						state_q <= ST_EXEC;
					end
				end
				ST_DONE: begin
					// hand the pose over once the output register is free
					if (!m_tvalid || m_tready) begin
						m_tdata <= {rgt_q, up_q, fwd_q, pos_q};
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/ocp_chk.sv
// ----------------------------------------------------------------------------
// ocp_chk: port level checks for the orbit camera unit
// output hold rules and request / result ordering, bound to the top level
// ----------------------------------------------------------------------------
module ocp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ocp_pkg::M_DATA_W-1:0]  m_tdata
);

	// a stalled result stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// returning to idle always comes with a fresh result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("request finished without a result");

endmodule

bind orbit_camera_pose_update_unit ocp_chk u_ocp_chk (.*);
